// File: rtl/core/cawm_pkg.sv
// Shared types and constants for the channel airtime utilization monitor.
// Used by cawm_ctrl, cawm_dp and the top level; no dependencies.
package cawm_pkg;

    // Field and register widths
    localparam int DWELL_W  = 11;
    localparam int LEN_W    = 12;
    localparam int RSSI_W   = 8;
    localparam int CHNUM_W  = 4;
    localparam int PCT_W    = 7;
    localparam int ACC_W    = 32;

    // Datapath widths
    localparam int PROD_W   = 41;   // frame count * 360
    localparam int N_W      = 42;   // bytes*8 + frames*360
    localparam int DSC_W    = 17;   // dwell * 60
    localparam int LIM_W    = 24;   // dwell * 6000
    localparam int Q_W      = PCT_W;
    localparam int DSH_W    = DSC_W + Q_W - 1;
    localparam int CNT_W    = 3;

    // Airtime scaling: load = (bytes*8 + frames*360) / (dwell_ms*60)
    localparam logic [8:0]          FRAME_WEIGHT = 9'd360;
    localparam logic [5:0]          DIV_SCALE    = 6'd60;
    localparam logic [12:0]         FULL_LIMIT   = 13'd6000;
    localparam logic [PCT_W-1:0]    FULL_LOAD    = 7'd100;
    localparam logic [RSSI_W-1:0]   RSSI_FLOOR   = 8'h80;
    localparam logic [DWELL_W-1:0]  DWELL_RESET  = 11'd350;
    localparam logic [CNT_W-1:0]    DIV_LAST     = 3'd6;

    // Request type codes
    localparam logic REQ_FRAME      = 1'b0;
    localparam logic REQ_WINDOW_END = 1'b1;

    // Register index codes (byte address bit 2)
    localparam logic REG_DWELL = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic acc;       // add a frame to the window
        logic snap;      // capture the window and clear it
        logic calc;      // frame count * 360
        logic sum;       // form the numerator, run the clamp test
        logic div_step;  // one restoring division step
        logic finish;    // publish the result, advance the channel
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a result
    } dp_status_t;

endpackage

// File: rtl/core/cawm_ctrl.sv
// Sequencer for the monitor: accepts requests and steps the datapath
// through the window-end computation. Depends on cawm_pkg.
module cawm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_req_type,
    output logic                   s_ready,
    input  cawm_pkg::dp_status_t   status,
    output cawm_pkg::ctrl_cmd_t    cmd
);
    import cawm_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             take;

    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (s_req_type == REQ_WINDOW_END) begin
                        cmd.snap   = 1'b1;
                        state_next = ST_CALC;
                    end else begin
                        cmd.acc = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/core/cawm_dp.sv
// Datapath of the monitor: window accumulators, numerator build, 7-step
// restoring divider, peak-hold table and output register. Uses cawm_pkg.
module cawm_dp #(
    parameter int NUM_CHANNELS = 11
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cawm_pkg::ctrl_cmd_t                   cmd,
    output cawm_pkg::dp_status_t                  status,
    input  logic [cawm_pkg::DWELL_W-1:0]          dwell,
    input  logic [cawm_pkg::LEN_W-1:0]            frame_length,
    input  logic signed [cawm_pkg::RSSI_W-1:0]    frame_rssi,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [cawm_pkg::CHNUM_W-1:0]          channel_number,
    output logic [cawm_pkg::PCT_W-1:0]            load_percent,
    output logic [cawm_pkg::PCT_W-1:0]            peak_percent,
    output logic signed [cawm_pkg::RSSI_W-1:0]    rssi_peak
);
    import cawm_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_CHANNELS - 1);

    // Window accumulators
    logic [ACC_W-1:0]         byte_total_reg, frame_total_reg;
    logic signed [RSSI_W-1:0] rssi_max_reg;
    logic [ACC_W:0]           byte_sum;
    logic [ACC_W-1:0]         byte_total_next, frame_total_next;

    // Window snapshot and division
    logic [ACC_W-1:0]         bsnap_reg, fsnap_reg;
    logic signed [RSSI_W-1:0] rssi_snap_reg;
    logic                     dz_reg, full_reg;
    logic [LIM_W-1:0]         lim_reg, lim_calc;
    logic [DSC_W-1:0]         dsc_calc;
    logic [DSH_W-1:0]         dsh_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [N_W-1:0]           rem_reg, num_calc;
    logic [Q_W-1:0]           quot_reg;
    logic                     step_fits;

    // Channel sweep and peak hold
    logic [IDX_W-1:0]         sweep_reg;
    logic [PCT_W-1:0]         peak_reg [NUM_CHANNELS];
    logic [PCT_W-1:0]         load_fin, peak_rd, peak_new;

    logic                     m_valid_reg;
    logic [CHNUM_W-1:0]       chnum_reg;
    logic [PCT_W-1:0]         load_reg, peakout_reg;
    logic signed [RSSI_W-1:0] rssi_out_reg;

    assign byte_sum         = {1'b0, byte_total_reg} + (ACC_W+1)'(frame_length);
    assign byte_total_next  = byte_sum[ACC_W] ? '1 : byte_sum[ACC_W-1:0];
    assign frame_total_next = (&frame_total_reg) ? frame_total_reg
                                                 : frame_total_reg + 1'b1;

    assign lim_calc  = LIM_W'(dwell) * LIM_W'(FULL_LIMIT);
    assign dsc_calc  = DSC_W'(dwell) * DSC_W'(DIV_SCALE);
    assign num_calc  = N_W'({bsnap_reg, 3'b000}) + N_W'(prod_reg);
    assign step_fits = (rem_reg >= N_W'(dsh_reg));

    assign load_fin = dz_reg   ? '0 :
                      full_reg ? FULL_LOAD : quot_reg;
    assign peak_rd  = peak_reg[sweep_reg];
    assign peak_new = (load_fin > peak_rd) ? load_fin : peak_rd;

    assign status.out_free = !m_valid_reg || m_ready;

    // Control state: accumulators, sweep, peak table, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_total_reg  <= '0;
            frame_total_reg <= '0;
            rssi_max_reg    <= RSSI_FLOOR;
            sweep_reg       <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                peak_reg[i] <= '0;
            end
        end else begin
            if (cmd.acc) begin
                byte_total_reg  <= byte_total_next;
                frame_total_reg <= frame_total_next;
                if (frame_rssi > rssi_max_reg) begin
                    rssi_max_reg <= frame_rssi;
                end
            end else if (cmd.snap) begin
                byte_total_reg  <= '0;
                frame_total_reg <= '0;
                rssi_max_reg    <= RSSI_FLOOR;
            end
            if (cmd.finish) begin
                m_valid_reg         <= 1'b1;
                peak_reg[sweep_reg] <= peak_new;
                sweep_reg           <= (sweep_reg == LAST_CH) ? '0 : sweep_reg + 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: snapshot, numerator, divider, output fields
    always_ff @(posedge aclk) begin
        if (cmd.snap) begin
            bsnap_reg     <= byte_total_reg;
            fsnap_reg     <= frame_total_reg;
            rssi_snap_reg <= (frame_total_reg != '0) ? rssi_max_reg : '0;
            dz_reg        <= (dwell == '0);
            lim_reg       <= lim_calc;
            dsh_reg       <= {dsc_calc, (Q_W-1)'(0)};
        end
        if (cmd.calc) begin
            prod_reg <= PROD_W'(fsnap_reg) * PROD_W'(FRAME_WEIGHT);
        end
        if (cmd.sum) begin
            rem_reg  <= num_calc;
            full_reg <= (num_calc >= N_W'(lim_reg));
            quot_reg <= '0;
        end
        if (cmd.div_step) begin
            if (step_fits) begin
                rem_reg  <= rem_reg - N_W'(dsh_reg);
                quot_reg <= {quot_reg[Q_W-2:0], 1'b1};
            end else begin
                quot_reg <= {quot_reg[Q_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.finish) begin
            chnum_reg    <= CHNUM_W'(sweep_reg) + 1'b1;
            load_reg     <= load_fin;
            peakout_reg  <= peak_new;
            rssi_out_reg <= rssi_snap_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign channel_number = chnum_reg;
    assign load_percent   = load_reg;
    assign peak_percent   = peakout_reg;
    assign rssi_peak      = rssi_out_reg;

endmodule

// File: rtl/core/channel_airtime_utilization_monitor.sv
// Channel airtime utilization monitor: APB dwell register, sequencer and
// datapath. Depends on cawm_pkg, cawm_ctrl and cawm_dp.
//
// Usage:
//   Input channel (s_*): one request per handshake. A frame request
//   (s_req_type = 0) adds its length, counts a frame and raises the window
//   RSSI peak; frames may arrive every cycle while s_ready is high.
//   A window-end request (s_req_type = 1) produces one result on the m_*
//   channel: channel number, load in percent, peak-hold load of that
//   channel and window RSSI peak. Load = (bytes*8/6 + frames*60 us) * 100
//   / (dwell_ms * 1000 us), clamped to 100, 0 when dwell_ms is 0.
//   The result is built by the product, numerator, 7-step restoring divider
//   and publish steps; s_ready stays low from the taking of the window-end
//   request until the result is published to the output register.
//   A pending result sits in the output register; frames are still taken
//   while it waits. If the receiver stalls, the next window-end request
//   holds in its final cycle until the output register is free.
//   Reset (aresetn low, synchronous) clears the window, the sweep index and
//   the peak-hold table and sets dwell_ms to 350. Write dwell_ms only while
//   idle (APB address 0).
module channel_airtime_utilization_monitor #(
    parameter int NUM_CHANNELS = 11
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // APB configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic [cawm_pkg::LEN_W-1:0]            s_frame_length,
    input  logic signed [cawm_pkg::RSSI_W-1:0]    s_frame_rssi,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [cawm_pkg::CHNUM_W-1:0]          m_channel_number,
    output logic [cawm_pkg::PCT_W-1:0]            m_load_percent,
    output logic [cawm_pkg::PCT_W-1:0]            m_peak_percent,
    output logic signed [cawm_pkg::RSSI_W-1:0]    m_rssi_peak
);
    import cawm_pkg::*;

    logic [DWELL_W-1:0] dwell_reg;
    logic               reg_sel;
    ctrl_cmd_t          cmd;
    dp_status_t         status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign prdata  = (reg_sel == REG_DWELL) ? 32'(dwell_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_reg <= DWELL_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel == REG_DWELL) begin
            dwell_reg <= pwdata[DWELL_W-1:0];
        end
    end

    cawm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    cawm_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .dwell          (dwell_reg),
        .frame_length   (s_frame_length),
        .frame_rssi     (s_frame_rssi),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .channel_number (m_channel_number),
        .load_percent   (m_load_percent),
        .peak_percent   (m_peak_percent),
        .rssi_peak      (m_rssi_peak)
    );

    a_load_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_load_percent <= FULL_LOAD)
        else $error("load above full scale");

    a_peak_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_peak_percent >= m_load_percent)
        else $error("peak-hold below window load");

    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_channel_number != '0 &&
                     m_channel_number <= CHNUM_W'(NUM_CHANNELS)))
        else $error("channel number out of sweep range");

    a_busy_after_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_WINDOW_END) |=> !s_ready)
        else $error("request taken during window-end computation");

endmodule
